### design/ldb_pkg.sv
// Shared types and constants for the LED duty brightness level block.
// Used by ldb_ctrl, ldb_datapath and the top level; no dependencies.
package ldb_pkg;

	localparam int ROWS        = 4;
	localparam int COLUMNS     = 16;
	localparam int COUNT_WIDTH = 20;
	localparam int LED_COUNT   = ROWS * COLUMNS;

	// Drive pattern fields carried in the input item
	localparam int IN_ROWS = 4;
	localparam int IN_COLS = 16;

	localparam int ROW_W   = 2;
	localparam int COL_W   = 4;
	localparam int LEVEL_W = 3;
	localparam int FRAC_W  = 16;

	localparam int DIV_STEPS = FRAC_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

	// Register indexes
	localparam logic [1:0] REG_LEVEL1 = 2'd0;
	localparam logic [1:0] REG_LEVEL2 = 2'd1;
	localparam logic [1:0] REG_LEVEL3 = 2'd2;
	localparam logic [1:0] REG_LEVEL4 = 2'd3;

	localparam logic [FRAC_W-1:0] LEVEL1_RESET = 16'd328;
	localparam logic [FRAC_W-1:0] LEVEL2_RESET = 16'd3277;
	localparam logic [FRAC_W-1:0] LEVEL3_RESET = 16'd13107;
	localparam logic [FRAC_W-1:0] LEVEL4_RESET = 16'd32768;

	// Input mode flag
	localparam logic MODE_CYCLE = 1'b0;
	localparam logic MODE_FRAME = 1'b1;

	typedef struct packed {
		logic count;   // cycle item accepted
		logic start;   // frame item accepted
		logic load;    // load divider from head LED
		logic step;    // one quotient bit
		logic commit;  // finish head LED, shift chains
	} ldb_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a result
		logic last_led;  // head LED is the final one of the frame
	} ldb_status_t;

endpackage

### design/ldb_ctrl.sv
// Controller state machine for the LED duty brightness level block.
// Depends on ldb_pkg; drives ldb_datapath through ldb_cmd_t.
module ldb_ctrl
	import ldb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_mode,
	output logic        in_ready,
	input  ldb_status_t status,
	output ldb_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic               accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.count  = accept && (in_mode == MODE_CYCLE);
		cmd.start  = accept && (in_mode == MODE_FRAME);
		cmd.load   = (state_q == ST_LOAD);
		cmd.step   = (state_q == ST_DIV);
		cmd.commit = (state_q == ST_FIN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_mode == MODE_FRAME)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (status.out_free) begin
						state_q <= status.last_led ? ST_IDLE : ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/ldb_datapath.sv
// Datapath: lit counters, brightness ring, serial divider, level compare
// and output register. Depends on ldb_pkg; commanded by ldb_ctrl.
module ldb_datapath
	import ldb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ldb_cmd_t              cmd,
	output ldb_status_t           status,
	input  logic [IN_DATA_W-1:0]  in_rows,
	input  logic                  wr_en,
	input  logic [1:0]            wr_index,
	input  logic [FRAC_W-1:0]     wr_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_column,
	output logic [LEVEL_W-1:0]    out_level,
	output logic                  out_last
);

	logic [FRAC_W-1:0]      th1_q, th2_q, th3_q, th4_q;
	logic [COUNT_WIDTH-1:0] cyc_q;
	logic [COUNT_WIDTH-1:0] lit_q    [LED_COUNT];
	logic [FRAC_W-1:0]      bright_q [LED_COUNT];
	logic [LED_COUNT-1:0]   rowbit_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [COUNT_WIDTH:0]   rem_q;
	logic [FRAC_W-1:0]      quo_q;
	logic                   eq_q;
	logic                   out_valid_q;
	logic [ROW_W-1:0]       out_row_q;
	logic [COL_W-1:0]       out_col_q;
	logic [LEVEL_W-1:0]     out_level_q;
	logic                   out_last_q;

	logic [LED_COUNT-1:0]   drive;
	logic                   full;
	logic [COUNT_WIDTH:0]   rem_sh;
	logic [COUNT_WIDTH:0]   divisor;
	logic                   rem_ge;
	logic [FRAC_W-1:0]      on_frac;
	logic [FRAC_W:0]        sum;
	logic [FRAC_W-1:0]      new_bright;
	logic [LEVEL_W-1:0]     new_level;
	logic                   last_led;

	// Map the item's row fields onto the LED order; missing rows read as dark
	always_comb begin
		drive = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLUMNS; c++) begin
				if (r < IN_ROWS && c < IN_COLS) begin
					drive[r*COLUMNS+c] = in_rows[r*IN_COLS+c];
				end
			end
		end
	end

	assign full     = &cyc_q;
	assign last_led = (row_q == ROW_W'(ROWS - 1)) && (col_q == COL_W'(COLUMNS - 1));

	assign status.out_free = !out_valid_q || out_ready;
	assign status.last_led = last_led;

	// Restoring division step; remainder stays at or below the divisor
	assign rem_sh  = {rem_q[COUNT_WIDTH-1:0], 1'b0};
	assign divisor = {1'b0, cyc_q};
	assign rem_ge  = (rem_sh >= divisor);

	always_comb begin
		if (cyc_q == '0) begin
			on_frac = {FRAC_W{rowbit_q[0]}};
		end else if (eq_q) begin
			on_frac = FRAC_MAX;
		end else begin
			on_frac = quo_q;
		end
		sum        = {1'b0, bright_q[0]} + {1'b0, on_frac};
		new_bright = sum[FRAC_W:1];
		// level climbs only while each threshold in turn is exceeded
		if (new_bright <= th1_q) begin
			new_level = 3'd0;
		end else if (new_bright <= th2_q) begin
			new_level = 3'd1;
		end else if (new_bright <= th3_q) begin
			new_level = 3'd2;
		end else if (new_bright <= th4_q) begin
			new_level = 3'd3;
		end else begin
			new_level = 3'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th1_q <= LEVEL1_RESET;
			th2_q <= LEVEL2_RESET;
			th3_q <= LEVEL3_RESET;
			th4_q <= LEVEL4_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEVEL1: th1_q <= wr_data;
				REG_LEVEL2: th2_q <= wr_data;
				REG_LEVEL3: th3_q <= wr_data;
				REG_LEVEL4: th4_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Counters, brightness ring and row walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q    <= '0;
			rowbit_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			for (int i = 0; i < LED_COUNT; i++) begin
				lit_q[i]    <= '0;
				bright_q[i] <= '0;
			end
		end else begin
			if (cmd.count && !full) begin
				cyc_q <= cyc_q + 1'b1;
				for (int i = 0; i < LED_COUNT; i++) begin
					lit_q[i] <= lit_q[i] + COUNT_WIDTH'(drive[i]);
				end
			end
			if (cmd.start) begin
				rowbit_q <= drive;
				row_q    <= '0;
				col_q    <= '0;
			end
			if (cmd.commit) begin
				// shifting zeros in clears the counters over the frame
				for (int i = 0; i < LED_COUNT - 1; i++) begin
					lit_q[i]    <= lit_q[i+1];
					bright_q[i] <= bright_q[i+1];
				end
				lit_q[LED_COUNT-1]    <= '0;
				bright_q[LED_COUNT-1] <= new_bright;
				rowbit_q <= {1'b0, rowbit_q[LED_COUNT-1:1]};
				if (col_q == COL_W'(COLUMNS - 1)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (last_led) begin
					cyc_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= {1'b0, lit_q[0]};
			quo_q <= '0;
			eq_q  <= (lit_q[0] == cyc_q);
		end else if (cmd.step) begin
			rem_q <= rem_ge ? (rem_sh - divisor) : rem_sh;
			quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_row_q   <= row_q;
			out_col_q   <= col_q;
			out_level_q <= new_level;
			out_last_q  <= last_led;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_column = out_col_q;
	assign out_level  = out_level_q;
	assign out_last   = out_last_q;

endmodule

### design/led_duty_brightness_levels_core.sv
// LED duty brightness levels: estimates panel LED brightness from drive duty.
//
// Input stream (s_*): tuser is the mode flag. Mode 0 is a bus-cycle item that
// adds each lit drive bit to its LED's lit counter; once the cycle counter is
// full, cycle items are taken and ignored. Mode 1 ends the frame.
// A cycle item is taken without leaving idle; s_tready is high whenever no frame is
// being worked on, so cycle items sustain one per clock.
// A frame item starts a serial pass over the 64 LEDs in row-major order. Each
// LED is taken through load, 16 steps of the one-bit-per-cycle divider and
// finish; s_tready is low for the whole pass, and the first result is
// presented once the first LED finishes. The pass clears the counters.
// Output stream (m_*): one item per LED; tlast marks the final LED. The result
// sits in an output register; if the receiver stalls, the pass holds at the
// next LED until the register frees, and nothing is dropped.
// Configuration: wr_en/wr_index/wr_data write the four level thresholds;
// write only while idle.
// Reset (arst_n low, asynchronous) clears counters and brightness to zero and
// restores the threshold defaults; the block is ready right after reset.
module led_duty_brightness_levels_core
	import ldb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] address_row, [31:16] data_row, [47:32] status_row, [63:48] misc_row
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// [0] mode
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] led_row, [5:2] led_column, [8:6] level, [15:9] zero
	output logic [OUT_DATA_W-1:0]  m_tdata,
	output logic                   m_tlast,
	input  logic                   wr_en,
	input  logic [1:0]             wr_index,
	input  logic [FRAC_W-1:0]      wr_data
);

	ldb_cmd_t            cmd;
	ldb_status_t         status;
	logic [ROW_W-1:0]    out_row;
	logic [COL_W-1:0]    out_column;
	logic [LEVEL_W-1:0]  out_level;

	ldb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ldb_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_rows    (s_tdata),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_row    (out_row),
		.out_column (out_column),
		.out_level  (out_level),
		.out_last   (m_tlast)
	);

	assign m_tdata = {{(OUT_DATA_W - ROW_W - COL_W - LEVEL_W){1'b0}},
		out_level, out_column, out_row};

endmodule
